/* sv/spf_pkg.sv */
// ----------------------------------------------------------------------------
// spf_pkg
// shared types and constants for the stepper position follower
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [PERIOD_W-1:0] period_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_CW   = 2'd1,
    MODE_CCW  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND   = 3'd0,
    REG_PRECISION  = 3'd1,
    REG_CUSHION    = 3'd2,
    REG_RAMP_STEP  = 3'd3,
    REG_BASE_PER   = 3'd4,
    REG_MIN_PER    = 3'd5
  } cfg_reg_t;

  localparam sample_t RST_DEADBAND  = 10'd16;
  localparam sample_t RST_PRECISION = 10'd2;
  localparam sample_t RST_CUSHION   = 10'd30;
  localparam sample_t RST_RAMP_STEP = 10'd1;
  localparam period_t RST_BASE_PER  = 16'd13880;
  localparam period_t RST_MIN_PER   = 16'd1250;
  localparam period_t PERIOD_MAX    = 16'hFFFF;

endpackage

/* sv/stepper_position_follower_unit.sv */
// ----------------------------------------------------------------------------
// stepper_position_follower_unit
// follows a commanded position with a stepper, one decision per sample pair
// ----------------------------------------------------------------------------
// a request is registered in the input reg, then in the result reg, before result valid
// throughput: one request per cycle while out_stall is low; the result register alone sets the pace
// a stalled result holds the input reg, then stalls the input channel
// reset: synchronous active-low rst_n; mode idle, flags and positions zero,
// step period and config registers at their reset values, no result pending
module stepper_position_follower_unit
  import spf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_order_sample,
  input  logic [SAMPLE_W-1:0]   in_response_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_motion_state,
  output logic                  out_direction_cw,
  output logic                  out_driver_enabled,
  output logic                  out_step_pulse,
  output logic [PERIOD_W-1:0]   out_pulse_half_period,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // config registers
  sample_t deadband_r, precision_r, cushion_r, ramp_step_r;
  period_t base_per_r, min_per_r;

  // input register
  logic    s1_valid_r;
  sample_t s1_order_r, s1_resp_r;

  // follower state
  mode_t   mode_r, mode_nxt;
  logic    near_start_r, near_start_nxt;
  logic    near_end_r, near_end_nxt;
  sample_t start_pos_r, start_pos_nxt;
  sample_t target_pos_r, target_pos_nxt;
  period_t step_period_r, step_period_nxt;

  // result register
  logic    out_valid_r;
  mode_t   out_mode_r;
  logic    out_dir_r, out_en_r, out_pulse_r;
  period_t out_half_r;

  logic    advance, s1_load;
  logic    up, moving;
  sample_t mag, dist_start, dist_end;
  period_t ramp_ext, dec_val, half_nxt;
  logic [PERIOD_W:0] inc_sum;
  logic    dir_nxt, en_nxt, pulse_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r  <= RST_DEADBAND;
      precision_r <= RST_PRECISION;
      cushion_r   <= RST_CUSHION;
      ramp_step_r <= RST_RAMP_STEP;
      base_per_r  <= RST_BASE_PER;
      min_per_r   <= RST_MIN_PER;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEADBAND:  deadband_r  <= cfg_data[SAMPLE_W-1:0];
        REG_PRECISION: precision_r <= cfg_data[SAMPLE_W-1:0];
        REG_CUSHION:   cushion_r   <= cfg_data[SAMPLE_W-1:0];
        REG_RAMP_STEP: ramp_step_r <= cfg_data[SAMPLE_W-1:0];
        REG_BASE_PER:  base_per_r  <= cfg_data[PERIOD_W-1:0];
        REG_MIN_PER:   min_per_r   <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign s1_load  = !s1_valid_r || advance;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_load) begin
      s1_order_r <= in_order_sample;
      s1_resp_r  <= in_response_sample;
    end
  end

  // difference and distances
  always_comb begin
    up         = s1_order_r > s1_resp_r;
    mag        = up ? s1_order_r - s1_resp_r : s1_resp_r - s1_order_r;
    moving     = mag > deadband_r;
    dist_start = (s1_resp_r > start_pos_r) ? s1_resp_r - start_pos_r
                                           : start_pos_r - s1_resp_r;
    dist_end   = (s1_resp_r > target_pos_r) ? s1_resp_r - target_pos_r
                                            : target_pos_r - s1_resp_r;
  end

  // next state
  always_comb begin
    mode_nxt       = mode_r;
    near_start_nxt = near_start_r;
    near_end_nxt   = near_end_r;
    start_pos_nxt  = start_pos_r;
    target_pos_nxt = target_pos_r;
    if (moving) begin
      mode_nxt       = up ? MODE_CW : MODE_CCW;
      near_start_nxt = dist_start <= cushion_r;
      near_end_nxt   = dist_end <= cushion_r;
    end else begin
      if (mag <= precision_r) begin
        mode_nxt = MODE_IDLE;
      end
      start_pos_nxt  = s1_resp_r;
      target_pos_nxt = s1_order_r;
    end
  end

  // step period ramp
  always_comb begin
    ramp_ext = {{(PERIOD_W-SAMPLE_W){1'b0}}, ramp_step_r};
    dec_val  = (step_period_r > ramp_ext) ? step_period_r - ramp_ext : '0;
    inc_sum  = {1'b0, step_period_r} + {1'b0, ramp_ext};
    if (mode_nxt == MODE_IDLE) begin
      step_period_nxt = base_per_r;
    end else if (near_start_nxt) begin
      step_period_nxt = dec_val;
    end else if (near_end_nxt) begin
      step_period_nxt = inc_sum[PERIOD_W] ? PERIOD_MAX : inc_sum[PERIOD_W-1:0];
    end else begin
      step_period_nxt = step_period_r;
    end
  end

  // outputs
  always_comb begin
    dir_nxt   = 1'b0;
    en_nxt    = 1'b0;
    pulse_nxt = 1'b0;
    half_nxt  = '0;
    case (mode_nxt)
      MODE_IDLE: ;
      MODE_CW: begin
        dir_nxt   = 1'b1;
        en_nxt    = 1'b1;
        pulse_nxt = 1'b1;
        half_nxt  = (step_period_nxt <= min_per_r) ? base_per_r : step_period_nxt;
      end
      MODE_CCW: begin
        en_nxt    = 1'b1;
        pulse_nxt = 1'b1;
        half_nxt  = (step_period_nxt <= min_per_r) ? base_per_r : step_period_nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      near_start_r  <= 1'b0;
      near_end_r    <= 1'b0;
      start_pos_r   <= '0;
      target_pos_r  <= '0;
      step_period_r <= RST_BASE_PER;
    end else if (advance) begin
      mode_r        <= mode_nxt;
      near_start_r  <= near_start_nxt;
      near_end_r    <= near_end_nxt;
      start_pos_r   <= start_pos_nxt;
      target_pos_r  <= target_pos_nxt;
      step_period_r <= step_period_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mode_r  <= mode_nxt;
      out_dir_r   <= dir_nxt;
      out_en_r    <= en_nxt;
      out_pulse_r <= pulse_nxt;
      out_half_r  <= half_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_motion_state      = out_mode_r;
  assign out_direction_cw      = out_dir_r;
  assign out_driver_enabled    = out_en_r;
  assign out_step_pulse        = out_pulse_r;
  assign out_pulse_half_period = out_half_r;

endmodule

/* sv/spf_checker.sv */
// ----------------------------------------------------------------------------
// spf_checker
// port-level checks for the stepper position follower
// ----------------------------------------------------------------------------
module spf_checker
  import spf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [1:0]            out_motion_state,
  input logic                  out_direction_cw,
  input logic                  out_driver_enabled,
  input logic                  out_step_pulse,
  input logic [PERIOD_W-1:0]   out_pulse_half_period
);

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pulse_half_period)
      && $stable(out_motion_state))
    else $error("stalled result dropped or changed");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_motion_state == MODE_IDLE |->
      !out_driver_enabled && !out_step_pulse && out_pulse_half_period == '0)
    else $error("idle result drives the motor");

  a_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_motion_state != MODE_IDLE |->
      out_driver_enabled && out_step_pulse
      && (out_direction_cw == (out_motion_state == MODE_CW)))
    else $error("moving result flags inconsistent");

  // with the result slot empty a new request is never refused
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(!out_valid) && $past(rst_n) |-> !in_stall)
    else $error("input stalled while pipeline empty");

endmodule

bind stepper_position_follower_unit spf_checker u_spf_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_motion_state      (out_motion_state),
  .out_direction_cw      (out_direction_cw),
  .out_driver_enabled    (out_driver_enabled),
  .out_step_pulse        (out_step_pulse),
  .out_pulse_half_period (out_pulse_half_period)
);
